// File: hdl/rafe_pkg.sv
// ----------------------------------------------------------------------------
// rafe_pkg: shared types and constants for the rotational anisotropy block
// Field widths, configuration register indexes and the pipeline control
// group passed from the top level to the arithmetic core.
// ----------------------------------------------------------------------------
package rafe_pkg;

	localparam int SPIN_W = 16;
	localparam int K_W = 24;
	localparam int FIELD_W = 32;
	localparam int MAT_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	// Register stages of the arithmetic pipeline.
	localparam int STAGES = 7;

	localparam int NUM_MATERIALS_DEF = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_K_BASE = 3'd1;

	localparam logic signed [FIELD_W-1:0] FIELD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [FIELD_W-1:0] FIELD_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [STAGES-1:0] adv;
		logic rot_enable;
	} stage_ctl_t;

endpackage

// File: hdl/rotational_anisotropy_field_energy.sv
// ----------------------------------------------------------------------------
// rotational_anisotropy_field_energy: fourth-order anisotropy field and energy
// Holds the configuration registers, selects the material constant and runs
// the valid/ready control of the seven-stage arithmetic pipeline.
// ----------------------------------------------------------------------------
// Each accepted input beat passes through the stage registers s1 to s7.
// Throughput: one beat per cycle unless the output stalls; each of the seven
// stages moves on its own, so a stalled output only holds occupied stages.
// Reset clears the configuration registers to zero and empties the pipeline.
// Configuration writes are taken every cycle.
module rotational_anisotropy_field_energy
	import rafe_pkg::*;
#(
	parameter int NUM_MATERIALS = NUM_MATERIALS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [SPIN_W-1:0]     spin_x,
	input  logic signed [SPIN_W-1:0]     spin_y,
	input  logic signed [SPIN_W-1:0]     spin_z,
	input  logic [MAT_W-1:0]             material,
	input  logic signed [FIELD_W-1:0]    field_in_x,
	input  logic signed [FIELD_W-1:0]    field_in_y,
	input  logic signed [FIELD_W-1:0]    field_in_z,
	input  logic                         last_atom,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [FIELD_W-1:0]    field_out_x,
	output logic signed [FIELD_W-1:0]    field_out_y,
	output logic signed [FIELD_W-1:0]    field_out_z,
	output logic signed [FIELD_W-1:0]    energy,
	output logic                         last_atom_out
);

	logic                    rot_enable_q;
	logic signed [K_W-1:0]   k_q [NUM_MATERIALS];
	logic [STAGES-1:0]       stage_vld_q;
	logic [STAGES-1:0]       adv;
	logic signed [K_W-1:0]   k_sel;
	stage_ctl_t              ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_enable_q <= 1'b0;
			for (int i = 0; i < NUM_MATERIALS; i++) begin
				k_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_ROT_ENABLE) begin
				rot_enable_q <= cfg_data[0];
			end
			for (int i = 0; i < NUM_MATERIALS; i++) begin
				if (cfg_index == REG_K_BASE + CFG_IDX_W'(i)) begin
					k_q[i] <= $signed(cfg_data[K_W-1:0]);
				end
			end
		end
	end

	// A material with no register of its own reads as a zero constant.
	always_comb begin
		k_sel = '0;
		for (int i = 0; i < NUM_MATERIALS; i++) begin
			if (material == MAT_W'(i)) begin
				k_sel = k_q[i];
			end
		end
	end

	// A stage may load whenever it is empty or the stage after it is moving.
	always_comb begin
		adv[STAGES-1] = !stage_vld_q[STAGES-1] || out_ready;
		for (int i = STAGES - 2; i >= 0; i--) begin
			adv[i] = !stage_vld_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (adv[0]) begin
				stage_vld_q[0] <= in_valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (adv[i]) begin
					stage_vld_q[i] <= stage_vld_q[i-1];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = stage_vld_q[STAGES-1];

	assign ctl.adv        = adv;
	assign ctl.rot_enable = rot_enable_q;

	rafe_core u_core (
		.clk           (clk),
		.ctl           (ctl),
		.spin_x        (spin_x),
		.spin_y        (spin_y),
		.k_in          (k_sel),
		.field_in_x    (field_in_x),
		.field_in_y    (field_in_y),
		.field_in_z    (field_in_z),
		.last_atom     (last_atom),
		.field_out_x   (field_out_x),
		.field_out_y   (field_out_y),
		.field_out_z   (field_out_z),
		.energy        (energy),
		.last_atom_out (last_atom_out)
	);

endmodule

// File: hdl/rafe_core.sv
// ----------------------------------------------------------------------------
// rafe_core: seven-stage arithmetic pipeline
// Evaluates the spin polynomials of the fourth-order anisotropy, scales them
// by the material constant with round-half-up, and if enabled adds the x/y
// increments to the field with saturation. Stages load on their advance bit.
// ----------------------------------------------------------------------------
module rafe_core
	import rafe_pkg::*;
(
	input  logic                      clk,
	input  stage_ctl_t                ctl,
	input  logic signed [SPIN_W-1:0]  spin_x,
	input  logic signed [SPIN_W-1:0]  spin_y,
	input  logic signed [K_W-1:0]     k_in,
	input  logic signed [FIELD_W-1:0] field_in_x,
	input  logic signed [FIELD_W-1:0] field_in_y,
	input  logic signed [FIELD_W-1:0] field_in_z,
	input  logic                      last_atom,
	output logic signed [FIELD_W-1:0] field_out_x,
	output logic signed [FIELD_W-1:0] field_out_y,
	output logic signed [FIELD_W-1:0] field_out_z,
	output logic signed [FIELD_W-1:0] energy,
	output logic                      last_atom_out
);

	localparam logic signed [87:0] E_HALF = 88'sd1 <<< 55;
	localparam logic signed [73:0] P_HALF = 74'sd1 <<< 41;

	// Stage 1: captured inputs.
	logic signed [SPIN_W-1:0]  sx_s1, sy_s1;
	logic signed [K_W-1:0]     k_s1;
	logic signed [FIELD_W-1:0] fx_s1, fy_s1, fz_s1;
	logic                      last_s1;

	// Stage 2: squares and cross product.
	logic signed [31:0]        sx2_s2, sy2_s2, p_s2;
	logic signed [SPIN_W-1:0]  sx_s2, sy_s2;
	logic signed [K_W-1:0]     k_s2;
	logic signed [FIELD_W-1:0] fx_s2, fy_s2, fz_s2;
	logic                      last_s2;

	// Stage 3: fourth- and third-order products.
	logic signed [61:0]        dd_s3, pp_s3;
	logic signed [48:0]        mx_s3, my_s3;
	logic signed [K_W-1:0]     k_s3;
	logic signed [FIELD_W-1:0] fx_s3, fy_s3, fz_s3;
	logic                      last_s3;

	// Stage 4: polynomials.
	logic signed [62:0]        q_s4;
	logic signed [49:0]        px_s4, py_s4;
	logic signed [K_W-1:0]     k_s4;
	logic signed [FIELD_W-1:0] fx_s4, fy_s4, fz_s4;
	logic                      last_s4;

	// Stage 5: partial products with the constant.
	logic signed [54:0]        kqh_s5;
	logic signed [56:0]        kql_s5, kxl_s5, kyl_s5;
	logic signed [41:0]        kxh_s5, kyh_s5;
	logic signed [FIELD_W-1:0] fx_s5, fy_s5, fz_s5;
	logic                      last_s5;

	// Stage 6: rounded energy and field increments.
	logic signed [FIELD_W-1:0] e_s6, incx_s6, incy_s6;
	logic signed [FIELD_W-1:0] fx_s6, fy_s6, fz_s6;
	logic                      last_s6;

	// Stage 7: output register.
	logic signed [FIELD_W-1:0] ox_s7, oy_s7, oz_s7, e_s7;
	logic                      last_s7;

	logic signed [31:0] d;
	logic signed [32:0] tx, ty;
	logic signed [30:0] qh;
	logic signed [32:0] ql, xl, yl;
	logic signed [17:0] xh, yh;
	logic signed [87:0] e_full;
	logic signed [73:0] x_full, y_full;
	logic signed [32:0] sum_x, sum_y;
	logic signed [FIELD_W-1:0] satx, saty;

	always_comb begin
		d  = sx2_s2 - sy2_s2;
		tx = 33'(sx2_s2) - 33'(sy2_s2) - (33'(sy2_s2) <<< 1);
		ty = 33'(sy2_s2) - 33'(sx2_s2) - (33'(sx2_s2) <<< 1);

		qh = $signed(q_s4[62:32]);
		ql = $signed({1'b0, q_s4[31:0]});
		xh = $signed(px_s4[49:32]);
		xl = $signed({1'b0, px_s4[31:0]});
		yh = $signed(py_s4[49:32]);
		yl = $signed({1'b0, py_s4[31:0]});

		e_full = (88'(kqh_s5) <<< 32) + 88'(kql_s5) + E_HALF;
		x_full = (74'(kxh_s5) <<< 32) + 74'(kxl_s5) + P_HALF;
		y_full = (74'(kyh_s5) <<< 32) + 74'(kyl_s5) + P_HALF;

		sum_x = 33'(fx_s6) + 33'(incx_s6);
		sum_y = 33'(fy_s6) + 33'(incy_s6);
		// The top two bits disagree exactly when the sum has left the 32-bit range.
		if (sum_x[32] != sum_x[31]) begin
			satx = sum_x[32] ? FIELD_MIN : FIELD_MAX;
		end else begin
			satx = sum_x[31:0];
		end
		if (sum_y[32] != sum_y[31]) begin
			saty = sum_y[32] ? FIELD_MIN : FIELD_MAX;
		end else begin
			saty = sum_y[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			sx_s1   <= spin_x;
			sy_s1   <= spin_y;
			k_s1    <= k_in;
			fx_s1   <= field_in_x;
			fy_s1   <= field_in_y;
			fz_s1   <= field_in_z;
			last_s1 <= last_atom;
		end
		if (ctl.adv[1]) begin
			sx2_s2  <= 32'(sx_s1) * 32'(sx_s1);
			sy2_s2  <= 32'(sy_s1) * 32'(sy_s1);
			p_s2    <= 32'(sx_s1) * 32'(sy_s1);
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			k_s2    <= k_s1;
			fx_s2   <= fx_s1;
			fy_s2   <= fy_s1;
			fz_s2   <= fz_s1;
			last_s2 <= last_s1;
		end
		if (ctl.adv[2]) begin
			// With d = sx^2 - sy^2 and p = sx*sy, sx^4 - 6sx^2sy^2 + sy^4 = d^2 - 4p^2.
			dd_s3   <= 62'(d) * 62'(d);
			pp_s3   <= 62'(p_s2) * 62'(p_s2);
			mx_s3   <= 49'(sx_s2) * 49'(tx);
			my_s3   <= 49'(sy_s2) * 49'(ty);
			k_s3    <= k_s2;
			fx_s3   <= fx_s2;
			fy_s3   <= fy_s2;
			fz_s3   <= fz_s2;
			last_s3 <= last_s2;
		end
		if (ctl.adv[3]) begin
			q_s4    <= 63'(dd_s3) - (63'(pp_s3) <<< 2);
			px_s4   <= -(50'(mx_s3) <<< 2);
			py_s4   <= -(50'(my_s3) <<< 2);
			k_s4    <= k_s3;
			fx_s4   <= fx_s3;
			fy_s4   <= fy_s3;
			fz_s4   <= fz_s3;
			last_s4 <= last_s3;
		end
		if (ctl.adv[4]) begin
			kqh_s5  <= 55'(k_s4) * 55'(qh);
			kql_s5  <= 57'(k_s4) * 57'(ql);
			kxh_s5  <= 42'(k_s4) * 42'(xh);
			kxl_s5  <= 57'(k_s4) * 57'(xl);
			kyh_s5  <= 42'(k_s4) * 42'(yh);
			kyl_s5  <= 57'(k_s4) * 57'(yl);
			fx_s5   <= fx_s4;
			fy_s5   <= fy_s4;
			fz_s5   <= fz_s4;
			last_s5 <= last_s4;
		end
		if (ctl.adv[5]) begin
			// All three scaled values are well inside 32 bits, so the upper slices hold them whole.
			e_s6    <= e_full[87:56];
			incx_s6 <= x_full[73:42];
			incy_s6 <= y_full[73:42];
			fx_s6   <= fx_s5;
			fy_s6   <= fy_s5;
			fz_s6   <= fz_s5;
			last_s6 <= last_s5;
		end
		if (ctl.adv[6]) begin
			ox_s7   <= ctl.rot_enable ? satx : fx_s6;
			oy_s7   <= ctl.rot_enable ? saty : fy_s6;
			oz_s7   <= fz_s6;
			e_s7    <= e_s6;
			last_s7 <= last_s6;
		end
	end

	assign field_out_x   = ox_s7;
	assign field_out_y   = oy_s7;
	assign field_out_z   = oz_s7;
	assign energy        = e_s7;
	assign last_atom_out = last_s7;

endmodule

// File: hdl/rafe_checker.sv
// ----------------------------------------------------------------------------
// rafe_checker: port-level checks for the rotational anisotropy block
// Watches the handshakes on the top level and the way backpressure spreads
// through the pipeline.
// ----------------------------------------------------------------------------
module rafe_checker
	import rafe_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [FIELD_W-1:0] field_out_x,
	input logic signed [FIELD_W-1:0] field_out_y,
	input logic signed [FIELD_W-1:0] field_out_z,
	input logic signed [FIELD_W-1:0] energy,
	input logic                      last_atom_out
);

	// A stalled output beat stays put until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(field_out_x)
			&& $stable(field_out_y) && $stable(field_out_z) && $stable(energy)
			&& $stable(last_atom_out))
		else $error("stalled output beat changed");

	// The input can only be refused when the output is held back.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without output backpressure");

	// Taking an output beat frees room at the input in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("output taken but input not ready");

	// A full, stalled pipeline stays full while the stall lasts, so the input
	// only opens again together with the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !out_ready |=> out_valid && (!in_ready || out_ready))
		else $error("full pipeline drained without an output beat");

endmodule

bind rotational_anisotropy_field_energy rafe_checker u_rafe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.field_out_x   (field_out_x),
	.field_out_y   (field_out_y),
	.field_out_z   (field_out_z),
	.energy        (energy),
	.last_atom_out (last_atom_out)
);
